>>> design/oep_pkg.sv
package oep_pkg;

	// Default number of entries in the element store.
	localparam int DEPTH_DEF = 64;

	// One accepted input transaction.
	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	// One emitted result transaction.
	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last_res;
		logic               overflow;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // store the accepted item, or note a drop when full
		logic init;      // set up the two indices for the partition
		logic rd_pair;   // read the entries at the left and right index
		logic rd_emit;   // read the entry at the emit index
		logic lo_step;   // left index moves right past an odd value
		logic hi_step;   // right index moves left past an even value
		logic swap_lo;   // first half of a swap: right entry goes to left slot
		logic swap_hi;   // second half of a swap, indices move inward
		logic emit;      // result is on the ports this cycle
		logic clear;     // list done, return to the empty state
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic lo_lt_hi;  // left index is below right index
		logic lo_odd;    // registered left entry is odd
		logic hi_even;   // registered right entry is even
		logic emit_last; // emit index points at the final stored entry
	} status_t;

endpackage

>>> design/odd_even_partition_unit.sv
// Odd/even partition unit. Drive start with one list element per transaction;
// the element is taken at a clock edge where start is high and busy is low,
// which allows one element per cycle while loading. The element marked last
// ends the list and starts the in-place two-pointer partition: every step of
// the left or right index takes one store read and one check, and every
// swap one store read, one check with the left write-back and one right
// write-back. The list is then emitted in store order, each element through
// the registered read of the element store; result_strobe marks each result
// for exactly one cycle and the receiver cannot hold results off, so it must
// take every strobed result. busy stays high from the last element until the
// final result. Elements beyond DEPTH are dropped and overflow is set on every
// result of that list. No clearing pass is needed after reset.
module odd_even_partition_unit #(
	parameter int DEPTH = oep_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  oep_pkg::item_t   item,
	output logic             busy,
	output logic             result_strobe,
	output oep_pkg::result_t result
);

	oep_pkg::cmd_t    cmd;
	oep_pkg::status_t status;

	// Sequencing of load, partition and emit.
	oep_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last          (item.last),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	// Element store, indices and result fields.
	oep_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

>>> design/oep_ctrl.sv
module oep_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last,
	input  oep_pkg::status_t  status,
	output oep_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              result_strobe
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_INIT = 7'b0000010,
		ST_RD   = 7'b0000100,
		ST_CHK  = 7'b0001000,
		ST_SWP  = 7'b0010000,
		ST_ERD  = 7'b0100000,
		ST_EOUT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_next;

	// Next state and command decode.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last) begin
						state_next = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init   = 1'b1;
				state_next = ST_RD;
			end
			ST_RD: begin
				if (status.lo_lt_hi) begin
					cmd.rd_pair = 1'b1;
					state_next  = ST_CHK;
				end else begin
					state_next = ST_ERD;
				end
			end
			ST_CHK: begin
				if (status.lo_odd) begin
					cmd.lo_step = 1'b1;
					state_next  = ST_RD;
				end else if (status.hi_even) begin
					cmd.hi_step = 1'b1;
					state_next  = ST_RD;
				end else begin
					cmd.swap_lo = 1'b1;
					state_next  = ST_SWP;
				end
			end
			ST_SWP: begin
				cmd.swap_hi = 1'b1;
				state_next  = ST_RD;
			end
			ST_ERD: begin
				cmd.rd_emit = 1'b1;
				state_next  = ST_EOUT;
			end
			ST_EOUT: begin
				cmd.emit = 1'b1;
				if (status.emit_last) begin
					cmd.clear  = 1'b1;
					state_next = ST_IDLE;
				end else begin
					state_next = ST_ERD;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = (state_q == ST_EOUT);

`ifndef NO_ASSERTIONS
	// The second half of a swap always follows the first.
	a_swap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_lo |=> cmd.swap_hi)
		else $error("swap not completed");

	// An end-of-list item always leads into the partition setup.
	a_last_init: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last) |=> cmd.init)
		else $error("partition not started after last item");

	// The block is idle right after the final result.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> !busy)
		else $error("block busy after final result");
`endif

endmodule

>>> design/oep_dpath.sv
module oep_dpath #(
	parameter int DEPTH = oep_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  oep_pkg::cmd_t     cmd,
	input  oep_pkg::item_t    item,
	output oep_pkg::status_t  status,
	output oep_pkg::result_t  result
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [IW-1:0] k_q;
	logic          dropped_q;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	logic          full;
	logic [IW-1:0] addr_a;
	logic [CW-1:0] last_pos;

	assign full     = (cnt_q == CW'(DEPTH));
	assign addr_a   = cmd.rd_emit ? k_q : lo_q;
	assign last_pos = cnt_q - 1'b1;

	// Fill count, drop flag and the three indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			k_q       <= '0;
		end else if (cmd.clear) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.init) begin
				lo_q <= '0;
				hi_q <= last_pos[IW-1:0];
			end
			if (cmd.lo_step || cmd.swap_hi) begin
				lo_q <= lo_q + 1'b1;
			end
			if (cmd.hi_step || cmd.swap_hi) begin
				hi_q <= hi_q - 1'b1;
			end
			if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Element store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[cnt_q[IW-1:0]] <= item.value;
		end else if (cmd.swap_lo) begin
			mem[lo_q] <= rd_b_q;
		end else if (cmd.swap_hi) begin
			mem[hi_q] <= rd_a_q;
		end
		if (cmd.rd_pair || cmd.rd_emit) begin
			rd_a_q <= mem[addr_a];
		end
		if (cmd.rd_pair) begin
			rd_b_q <= mem[hi_q];
		end
	end

	// Status back to the controller.
	assign status.lo_lt_hi  = (lo_q < hi_q);
	assign status.lo_odd    = rd_a_q[0];
	assign status.hi_even   = !rd_b_q[0];
	assign status.emit_last = ({1'b0, k_q} == (IW + 1)'(last_pos));

	// Result fields, valid while the controller strobes.
	assign result.value_res = rd_a_q;
	assign result.last_res  = status.emit_last;
	assign result.overflow  = dropped_q;

`ifndef NO_ASSERTIONS
	// The fill count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count beyond store depth");

	// A swap only happens between distinct slots in the right order.
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_lo |-> (lo_q < hi_q))
		else $error("swap with crossed indices");

	// Emitting only reads entries written for the current list.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_emit |-> ((CW + 1)'(k_q) < (CW + 1)'(cnt_q)))
		else $error("emit index beyond fill count");

	// Clearing empties the list and drops the overflow mark.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (cnt_q == '0) && !dropped_q)
		else $error("list state not cleared");
`endif

endmodule
